FILE: rtl/core/command_frame_builder_crc16_macros.svh
// ----------------------------------------------------------------------------
// Command frame builder assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_CRC16_MACROS_SVH
`define COMMAND_FRAME_BUILDER_CRC16_MACROS_SVH

// Generic clocked assertion with a fixed message.
`define CFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("command frame builder assertion failed");

// Same, with a caller-supplied message.
`define CFB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/cfb_pkg.sv
// ----------------------------------------------------------------------------
// Command frame builder package
// Step codes, emit struct and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package cfb_pkg;

  // Byte positions within a frame
  typedef logic [2:0] step_t;
  localparam step_t STEP_INIT = 3'd0;
  localparam step_t STEP_DEV  = 3'd1;
  localparam step_t STEP_AHI  = 3'd2;
  localparam step_t STEP_ALO  = 3'd3;
  localparam step_t STEP_DATA = 3'd4;
  localparam step_t STEP_CLO  = 3'd5;
  localparam step_t STEP_CHI  = 3'd6;

  localparam logic [7:0]  INIT_BASE = 8'h80;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // One byte leaving the sequencer
  typedef struct packed {
    logic       valid;
    step_t      step;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cfb_seq.sv
// ----------------------------------------------------------------------------
// Command frame builder sequencer
// Holds one input word and steps through the frame bytes it produces.
// ----------------------------------------------------------------------------
module cfb_seq #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     request_type_i,
  input  logic [7:0]     device_id_i,
  input  logic [15:0]    reg_addr_i,
  input  logic [3:0]     payload_count_i,
  input  logic [7:0]     data_byte_i,
  input  logic           frame_end_i,
  input  logic           load_ok_i,
  input  logic [15:0]    crc_i,
  output cfb_pkg::emit_t emit_o
);
  import cfb_pkg::*;

  localparam logic [3:0] MaxCnt = 4'(MAX_PAYLOAD);

  logic       hold_valid_q, hold_valid_d;
  logic       inside_q, inside_d;
  step_t      step_q, step_d, step_nxt;
  logic [7:0] init_q, init_d;
  logic       single_q, single_d;
  logic [7:0] dev_q, dev_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;

  logic       fire, final_step, accept;
  logic [3:0] cnt_sat;
  logic [3:0] len;
  logic [7:0] byte_sel;

  // Saturated payload count and length field (count minus one)
  always_comb begin
    cnt_sat = payload_count_i;
    if (cnt_sat == 4'd0)  cnt_sat = 4'd1;
    if (cnt_sat > MaxCnt) cnt_sat = MaxCnt;
    len = cnt_sat - 4'd1;
  end

  assign fire       = hold_valid_q & load_ok_i;
  assign final_step = ((step_q == STEP_DATA) & ~last_q) | (step_q == STEP_CHI);
  assign in_ready_o = ~hold_valid_q | (fire & final_step);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    byte_sel = data_q;
    step_nxt = STEP_DATA;
    unique case (step_q)
      STEP_INIT: begin
        byte_sel = init_q;
        step_nxt = single_q ? STEP_DEV : STEP_AHI;
      end
      STEP_DEV: begin
        byte_sel = dev_q;
        step_nxt = STEP_AHI;
      end
      STEP_AHI: begin
        byte_sel = addr_q[15:8];
        step_nxt = STEP_ALO;
      end
      STEP_ALO: begin
        byte_sel = addr_q[7:0];
        step_nxt = STEP_DATA;
      end
      STEP_DATA: begin
        byte_sel = data_q;
        step_nxt = STEP_CLO;
      end
      STEP_CLO: begin
        byte_sel = crc_i[7:0];
        step_nxt = STEP_CHI;
      end
      STEP_CHI: begin
        byte_sel = crc_i[15:8];
        step_nxt = STEP_INIT;
      end
      default: begin
        byte_sel = data_q;
        step_nxt = STEP_INIT;
      end
    endcase
  end

  assign emit_o.valid = fire;
  assign emit_o.step  = step_q;
  assign emit_o.data  = byte_sel;
  assign emit_o.last  = (step_q == STEP_CHI);

  always_comb begin
    hold_valid_d = hold_valid_q;
    inside_d     = inside_q;
    step_d       = step_q;
    init_d       = init_q;
    single_d     = single_q;
    dev_d        = dev_q;
    addr_d       = addr_q;
    data_d       = data_q;
    last_d       = last_q;
    if (accept) begin
      hold_valid_d = 1'b1;
      inside_d     = ~frame_end_i;
      step_d       = inside_q ? STEP_DATA : STEP_INIT;
      init_d       = INIT_BASE | {1'b0, request_type_i, 4'h0}
                   | (request_type_i[0] ? {4'h0, len} : 8'h00);
      single_d     = (request_type_i[2:1] == 2'b00);
      dev_d        = device_id_i;
      addr_d       = reg_addr_i;
      data_d       = data_byte_i;
      last_d       = frame_end_i;
    end else if (fire) begin
      hold_valid_d = ~final_step;
      step_d       = step_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      inside_q     <= 1'b0;
      step_q       <= STEP_INIT;
    end else begin
      hold_valid_q <= hold_valid_d;
      inside_q     <= inside_d;
      step_q       <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q   <= init_d;
    single_q <= single_d;
    dev_q    <= dev_d;
    addr_q   <= addr_d;
    data_q   <= data_d;
    last_q   <= last_d;
  end

endmodule

FILE: rtl/core/cfb_crc.sv
// ----------------------------------------------------------------------------
// Command frame builder CRC
// Running CRC-16 over every header and payload byte of the frame.
// ----------------------------------------------------------------------------
module cfb_crc (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfb_pkg::emit_t emit_i,
  output logic [15:0]    crc_o
);
  import cfb_pkg::*;

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (emit_i.valid) begin
      unique case (emit_i.step)
        STEP_INIT:                               crc_d = crc_feed(CRC_INIT, emit_i.data);
        STEP_DEV, STEP_AHI, STEP_ALO, STEP_DATA: crc_d = crc_feed(crc_q, emit_i.data);
        STEP_CLO:                                crc_d = crc_q;
        STEP_CHI:                                crc_d = CRC_INIT;
        default:                                 crc_d = crc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

FILE: rtl/core/cfb_out.sv
// ----------------------------------------------------------------------------
// Command frame builder output register
// One-word output stage toward the master side.
// ----------------------------------------------------------------------------
module cfb_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfb_pkg::emit_t emit_i,
  output logic           load_ok_o,
  output logic           tvalid_o,
  input  logic           tready_i,
  output logic [7:0]     tdata_o,
  output logic           tlast_o
);
  import cfb_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;

  assign load_ok_o = ~valid_q | tready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (load_ok_o) begin
      valid_d = emit_i.valid;
      data_d  = emit_i.data;
      last_d  = emit_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;
  assign tlast_o  = last_q;

endmodule

FILE: rtl/core/command_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// Command frame builder with CRC-16 trailer
// Serializes payload words into command frames: header, payload, CRC.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser        | tlast
//  s_axis   | in  | device_id, reg_addr,           | request_type | frame_end
//           |     | payload_count, data_byte       |              |
//  m_axis   | out | out_byte                       | -            | out_last
//
//  Each accepted word yields one output word per cycle while the output
//  register can load: 1 for a mid-frame payload word, up to 7 for a one-word
//  frame (init, device id, address high/low, data, CRC low/high), at the
//  sequencer's byte step; unstalled mid-frame words stream one per cycle.
//  Reset: all control state cleared, running CRC back to 0xFFFF, no frame open.
//  Stalls: s_axis_tready_o is high while the hold stage is empty, or in the
//  cycle its word sends its final byte into a free output register; each
//  header and CRC byte ahead of that final byte holds the input off.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16 #(
  parameter int MAX_PAYLOAD = 8    // payload count saturation, 1..8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [7:0] device_id, [23:8] reg_addr,
                                       // [27:24] payload_count, [35:28] data_byte,
                                       // [39:36] zero
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] request_type
  input  logic        s_axis_tlast_i,  // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tlast_o   // out_last
);
  import cfb_pkg::*;

  emit_t       emit;
  logic        load_ok;
  logic [15:0] crc;

  // Input hold stage and byte sequencer
  cfb_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .request_type_i  (s_axis_tuser_i),
    .device_id_i     (s_axis_tdata_i[7:0]),
    .reg_addr_i      (s_axis_tdata_i[23:8]),
    .payload_count_i (s_axis_tdata_i[27:24]),
    .data_byte_i     (s_axis_tdata_i[35:28]),
    .frame_end_i     (s_axis_tlast_i),
    .load_ok_i       (load_ok),
    .crc_i           (crc),
    .emit_o          (emit)
  );

  // Running CRC, updated as header and payload bytes leave the sequencer
  cfb_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .crc_o  (crc)
  );

  // Output register
  cfb_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .emit_i    (emit),
    .load_ok_o (load_ok),
    .tvalid_o  (m_axis_tvalid_o),
    .tready_i  (m_axis_tready_i),
    .tdata_o   (m_axis_tdata_o),
    .tlast_o   (m_axis_tlast_o)
  );

endmodule

FILE: rtl/core/cfb_checker.sv
// ----------------------------------------------------------------------------
// Command frame builder port checker
// Port-level checks on stalls and frame endings, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_frame_builder_crc16_macros.svh"

module cfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic       s_acc, m_stall, m_last_acc;
  logic [8:0] m_word;

  assign s_acc      = s_axis_tvalid_i & s_axis_tready_o;
  assign m_stall    = m_axis_tvalid_o & ~m_axis_tready_i;
  assign m_last_acc = m_axis_tvalid_o & m_axis_tready_i & m_axis_tlast_o;
  assign m_word     = {m_axis_tlast_o, m_axis_tdata_o};

  // Stalled output word holds
  `CFB_ASSERT(a_out_hold, m_stall |=> m_axis_tvalid_o && $stable(m_word))

  // A word taken during a stall fills the hold stage; a second stall cycle blocks input
  `CFB_ASSERT(a_in_block, (m_stall && s_acc) ##1 m_stall |-> !s_axis_tready_o)

  // The word after a frame's last byte never closes another frame
  `CFB_ASSERT(a_no_back_to_back_last, m_last_acc |=> !(m_axis_tvalid_o && m_axis_tlast_o))

  // No output appears the cycle after reset releases
  `CFB_ASSERT_MSG(a_reset_quiet, $rose(rst_ni) |-> !m_axis_tvalid_o, "output valid out of reset")

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
